// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for concurrent assertions clocked on a rising edge with an
// active-low reset that disables them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent holds at the next clock edge.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted leaf table package
// Sizes, operation and status codes, and the structs passed along the row
// of table cells.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int CAPACITY      = 16;
	localparam int KEY_WIDTH     = 32;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int IDX_W         = $clog2(CAPACITY);
	localparam int CAP_W         = 5;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_MISSING   = 3'd4;

	// Contents of one slot as seen by its right-hand neighbour.
	typedef struct packed {
		logic                         valid;
		logic signed [KEY_WIDTH-1:0]  key;
		logic [PAYLOAD_WIDTH-1:0]     payload;
	} entry_t;

	// Broadcast to every cell: the incoming record and the insert strobe.
	typedef struct packed {
		logic                         commit;
		logic signed [KEY_WIDTH-1:0]  key;
		logic [PAYLOAD_WIDTH-1:0]     payload;
	} cmd_t;

	// Per-cell compare results.
	typedef struct packed {
		logic lower;   // valid and stored key below the incoming key
		logic here;    // the incoming record belongs in this slot
		logic match;   // valid and stored key equal to the incoming key
	} flags_t;

endpackage

// ----- design/slt_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted leaf table cell
// One slot of the table: compares its key with the incoming key and, on an
// insert, keeps its record, takes the new one or takes its left neighbour's.
// ----------------------------------------------------------------------------
module slt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  slt_pkg::cmd_t   cmd,
	input  slt_pkg::entry_t left_ent,
	input  logic            left_before,
	output slt_pkg::entry_t ent,
	output slt_pkg::flags_t flg
);
	import slt_pkg::*;

	logic                        valid_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic [PAYLOAD_WIDTH-1:0]    payload_q;

	always_comb begin
		flg.lower = valid_q && ($signed(key_q) < $signed(cmd.key));
		flg.match = valid_q && (key_q == cmd.key);
		flg.here  = !flg.lower && left_before;
	end

	assign ent = '{valid: valid_q, key: key_q, payload: payload_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.commit && !flg.lower) begin
			valid_q <= valid_q || left_ent.valid;
		end
	end

	// Slots after the insertion point move up by one.
	always_ff @(posedge clk) begin
		if (cmd.commit && !flg.lower) begin
			if (left_before) begin
				key_q     <= cmd.key;
				payload_q <= cmd.payload;
			end else begin
				key_q     <= left_ent.key;
				payload_q <= left_ent.payload;
			end
		end
	end

endmodule

// ----- design/sorted_leaf_table.sv -----
// ----------------------------------------------------------------------------
// Sorted leaf table
// Up to sixteen key/payload records held in ascending signed key order,
// with insert, find by key and read by index.
// ----------------------------------------------------------------------------
// The table is a row of sixteen cells, one slot each. Every cell compares the
// incoming key with its own key at once, and on an insert each cell above the
// insertion point takes its left neighbour's record in the same cycle. The
// result of an accepted transfer is written to the output register at the edge
// that accepts it, and a new transfer is accepted every cycle while the result
// side keeps up. The depth of the compare, the shift multiplexer in each cell
// and the sixteen-way result selection set the clock period. Inserts report
// full once the record count reaches capacity_in_use, saturated at sixteen; find
// and read still see every record held. The user must write capacity_in_use
// only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sorted_leaf_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,   // capacity_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,    // op[1:0], key[33:2], payload[65:34], index[69:66]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata     // status[2:0], position[6:3], key_out[38:7],
	                                // payload_out[70:39]
);
	import slt_pkg::*;

	`include "assert_macros.svh"

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic             m_valid_q;
	logic [71:0]      m_data_q;

	logic [1:0]                  in_op;
	logic signed [KEY_WIDTH-1:0] in_key;
	logic [PAYLOAD_WIDTH-1:0]    in_payload;
	logic [IDX_W-1:0]            in_index;

	entry_t          ent   [CAPACITY];
	flags_t          flg   [CAPACITY];
	logic [CAPACITY-1:0] valid_vec;
	cmd_t            cmd;

	logic                        accept;
	logic [CNT_W-1:0]            limit;
	logic                        full;
	logic                        dup;
	logic [IDX_W-1:0]            ins_pos;
	logic                        hit;
	logic [IDX_W-1:0]            hit_pos;
	logic signed [KEY_WIDTH-1:0] hit_key;
	logic [PAYLOAD_WIDTH-1:0]    hit_payload;
	logic [2:0]                  res_status;
	logic [IDX_W-1:0]            res_pos;
	logic signed [KEY_WIDTH-1:0] res_key;
	logic [PAYLOAD_WIDTH-1:0]    res_payload;

	assign in_op      = s_tdata[1:0];
	assign in_key     = s_tdata[33:2];
	assign in_payload = s_tdata[65:34];
	assign in_index   = s_tdata[69:66];

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	assign limit = (cap_q > CAP_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(cap_q);
	assign full  = (count_q >= limit);

	assign cmd.commit  = accept && (in_op == OP_INSERT) && !full && !dup;
	assign cmd.key     = in_key;
	assign cmd.payload = in_payload;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			slt_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.left_ent    ('{valid: 1'b1, key: '0, payload: '0}),
				.left_before (1'b1),
				.ent         (ent[i]),
				.flg         (flg[i])
			);
		end else begin : g_next
			slt_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.left_ent    (ent[i-1]),
				.left_before (flg[i-1].lower),
				.ent         (ent[i]),
				.flg         (flg[i])
			);
		end
		assign valid_vec[i] = ent[i].valid;
	end

	// Keys are unique, so at most one cell matches and the selection is an OR.
	always_comb begin
		dup         = 1'b0;
		ins_pos     = '0;
		hit_pos     = '0;
		hit_key     = '0;
		hit_payload = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			dup = dup | flg[i].match;
			if (flg[i].here) begin
				ins_pos = ins_pos | IDX_W'(i);
			end
			if (flg[i].match) begin
				hit_pos     = hit_pos | IDX_W'(i);
				hit_key     = hit_key | ent[i].key;
				hit_payload = hit_payload | ent[i].payload;
			end
		end
		hit = dup;
	end

	always_comb begin
		res_status  = ST_MISSING;
		res_pos     = '0;
		res_key     = '0;
		res_payload = '0;
		unique case (in_op)
			OP_INSERT: begin
				if (full) begin
					res_status = ST_FULL;
				end else if (dup) begin
					res_status = ST_DUPLICATE;
				end else begin
					res_status = ST_INSERTED;
					res_pos    = ins_pos;
				end
			end
			OP_FIND: begin
				if (hit) begin
					res_status  = ST_FOUND;
					res_pos     = hit_pos;
					res_key     = hit_key;
					res_payload = hit_payload;
				end
			end
			OP_READ: begin
				if (CNT_W'(in_index) < count_q) begin
					res_status  = ST_FOUND;
					res_pos     = in_index;
					res_key     = ent[in_index].key;
					res_payload = ent[in_index].payload;
				end
			end
			default: begin
				res_status = ST_MISSING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_W'(CAPACITY);
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (cmd.commit) begin
				count_q <= count_q + 1'b1;
			end
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {1'b0, res_payload, res_key, res_pos, res_status};
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY))
	`ASSERT_ALWAYS(a_valid_count, clk, arst_n, $countones(valid_vec) == int'(count_q))
	`ASSERT_NEXT(a_insert_grows, clk, arst_n, cmd.commit, count_q == $past(count_q) + 1'b1 && m_tdata[2:0] == ST_INSERTED)

endmodule

// ----- tb/sorted_leaf_table_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted leaf table checker
// Watches the configuration, input and result channels. It keeps its own
// copy of the sorted table to predict each result, and compares every
// result transfer field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module sorted_leaf_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,    // op[1:0], key[33:2], payload[65:34], index[69:66]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,    // status[2:0], position[6:3], key_out[38:7],
	                                // payload_out[70:39]
	output int          pending,
	output int          fail_count,
	output int          checked,
	output int          records_held
);
	import slt_pkg::*;

	typedef struct {
		logic [2:0]                  status;
		logic [3:0]                  position;
		logic signed [KEY_WIDTH-1:0] key_out;
		logic [PAYLOAD_WIDTH-1:0]    payload_out;
	} leaf_result_t;

	logic signed [KEY_WIDTH-1:0] slot_keys [CAPACITY];
	logic [PAYLOAD_WIDTH-1:0]    slot_payloads [CAPACITY];
	logic [CAP_W-1:0]            cap_limit;
	int                          held;
	leaf_result_t                awaited [$];
	leaf_result_t                want;
	leaf_result_t                got;

	// Applies one operation to the table copy and returns the result it gives.
	function automatic leaf_result_t leaf_outcome(input logic [1:0] op,
			input logic signed [KEY_WIDTH-1:0] key, input logic [PAYLOAD_WIDTH-1:0] pay,
			input logic [3:0] idx);
		leaf_result_t r;
		int           lim;
		int           at;
		int           i;
		bit           dup;
		bit           hit;
		r.status      = ST_MISSING;
		r.position    = '0;
		r.key_out     = '0;
		r.payload_out = '0;
		case (op)
			OP_INSERT: begin
				lim = (cap_limit < CAPACITY) ? cap_limit : CAPACITY;
				if (held >= lim) begin
					r.status = ST_FULL;
				end else begin
					at  = held;
					dup = 1'b0;
					for (i = 0; i < held; i++) begin
						if (!dup && at == held) begin
							if (key == slot_keys[i])
								dup = 1'b1;
							else if (key < slot_keys[i])
								at = i;
						end
					end
					if (dup) begin
						r.status = ST_DUPLICATE;
					end else begin
						for (i = held; i > at; i--) begin
							slot_keys[i]     = slot_keys[i-1];
							slot_payloads[i] = slot_payloads[i-1];
						end
						slot_keys[at]     = key;
						slot_payloads[at] = pay;
						held++;
						r.status   = ST_INSERTED;
						r.position = at[3:0];
					end
				end
			end
			OP_FIND: begin
				hit = 1'b0;
				for (i = 0; i < held; i++) begin
					if (!hit && slot_keys[i] == key) begin
						hit           = 1'b1;
						r.status      = ST_FOUND;
						r.position    = i[3:0];
						r.key_out     = slot_keys[i];
						r.payload_out = slot_payloads[i];
					end
				end
			end
			OP_READ: begin
				if (idx < held) begin
					r.status      = ST_FOUND;
					r.position    = idx;
					r.key_out     = slot_keys[idx];
					r.payload_out = slot_payloads[idx];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Results are checked before the new input is predicted, because a result
	// leaving at an edge never belongs to the input accepted at that edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held       = 0;
			cap_limit  = CAP_W'(CAPACITY);
			fail_count = 0;
			checked    = 0;
			awaited.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.status      = m_tdata[2:0];
				got.position    = m_tdata[6:3];
				got.key_out     = m_tdata[38:7];
				got.payload_out = m_tdata[70:39];
				if (awaited.size() == 0) begin
					$error("result transfer with nothing expected: %h", m_tdata);
					fail_count++;
				end else begin
					want = awaited.pop_front();
					checked++;
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, got.position);
						fail_count++;
					end
					if (got.key_out !== want.key_out) begin
						$error("key_out: expected %0d, got %0d", want.key_out, got.key_out);
						fail_count++;
					end
					if (got.payload_out !== want.payload_out) begin
						$error("payload_out: expected %h, got %h", want.payload_out,
							got.payload_out);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				cap_limit = cfg_data;
			if (s_tvalid && s_tready)
				awaited.push_back(leaf_outcome(s_tdata[1:0], s_tdata[33:2], s_tdata[65:34],
					s_tdata[69:66]));
		end
		pending      = awaited.size();
		records_held = held;
	end

endmodule

// ----- tb/sorted_leaf_table_test.sv -----
// ----------------------------------------------------------------------------
// Sorted leaf table test
// Drives a directed sequence of inserts, finds, reads and unused operations,
// then random traffic over a sweep of capacity settings, with random gaps on
// the input side and random stalls on the result side. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_leaf_table_test;
	import slt_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         PHASE_ITEMS = 142;
	localparam int         PHASES      = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;

	int pending;
	int fail_count;
	int checked;
	int records_held;
	int idle_pct;
	int stall_pct;
	int stall_left;
	int cycles;
	int ops_sent;
	int cap_writes;

	logic signed [KEY_WIDTH-1:0] sent_keys [$];
	logic [CAP_W-1:0]            phase_caps [PHASES] = '{5'd3, 5'd9, 5'd1, 5'd31, 5'd0,
		5'd17, 5'd12, 5'd16};

	sorted_leaf_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	sorted_leaf_table_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.pending      (pending),
		.fail_count   (fail_count),
		.checked      (checked),
		.records_held (records_held)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stalls, each a burst of low tready, at a rate set by stall_pct.
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				m_tready   <= 1'b0;
				stall_left = $urandom_range(1, 8) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offers one item, possibly after a gap, and returns at the edge of its
	// transfer with tvalid still high so that the next item can follow at once.
	task automatic push_op(input logic [1:0] op, input logic signed [KEY_WIDTH-1:0] key,
			input logic [PAYLOAD_WIDTH-1:0] pay, input logic [3:0] idx);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, idx, pay, key, op};
		do @(posedge clk); while (!s_tready);
		ops_sent++;
		if (op == OP_INSERT && sent_keys.size() < 64)
			sent_keys.push_back(key);
	endtask

	// The capacity is only changed once every outstanding result has left.
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	initial begin
		int                          p;
		int                          k;
		int                          r;
		logic [1:0]                  op;
		logic signed [KEY_WIDTH-1:0] key;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		idle_pct   = 20;
		stall_pct  = 20;
		ops_sent   = 0;
		cap_writes = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table at the reset capacity, and the unused operation.
		push_op(OP_READ, 32'sd0, 32'h0, 4'd0);
		push_op(OP_FIND, 32'sd0, 32'h0, 4'd0);
		push_op(OP_UNUSED, -32'sd1, 32'hFFFF_FFFF, 4'hF);
		// Key extremes, a duplicate, and an insert between stored keys.
		push_op(OP_INSERT, 32'sd0, 32'h0000_0000, 4'd0);
		push_op(OP_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 4'd0);
		push_op(OP_INSERT, 32'sh8000_0000, 32'hA5A5_A5A5, 4'd0);
		push_op(OP_INSERT, -32'sd1, 32'h5A5A_5A5A, 4'd0);
		push_op(OP_INSERT, 32'sd0, 32'h0000_0001, 4'd0);
		push_op(OP_INSERT, 32'sd1, 32'h1234_5678, 4'd0);
		push_op(OP_FIND, 32'sh8000_0000, 32'h0, 4'd0);
		push_op(OP_FIND, 32'sh7FFF_FFFF, 32'h0, 4'd0);
		push_op(OP_FIND, 32'sd2, 32'h0, 4'd0);
		push_op(OP_READ, 32'sd0, 32'h0, 4'd4);
		push_op(OP_READ, 32'sd0, 32'h0, 4'd5);
		push_op(OP_READ, 32'sd0, 32'h0, 4'd15);
		// A zero capacity refuses every insert but leaves the records visible.
		set_capacity(5'd0);
		push_op(OP_INSERT, 32'sd100, 32'hDEAD_BEEF, 4'd0);
		push_op(OP_FIND, -32'sd1, 32'h0, 4'd0);
		// A capacity below the record count still lets find and read see all.
		set_capacity(5'd2);
		push_op(OP_INSERT, 32'sd2, 32'h0, 4'd0);
		push_op(OP_READ, 32'sd0, 32'h0, 4'd0);
		push_op(OP_FIND, 32'sd1, 32'h0, 4'd0);

		for (p = 0; p < PHASES; p++) begin
			set_capacity(phase_caps[p]);
			if (p == PHASES - 1) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else begin
				idle_pct  = 15 * $urandom_range(0, 3);
				stall_pct = 15 * $urandom_range(0, 3);
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(99);
				if (r < 30)
					op = OP_INSERT;
				else if (r < 60)
					op = OP_FIND;
				else if (r < 95)
					op = OP_READ;
				else
					op = OP_UNUSED;
				// Reuse earlier keys often so that duplicates and find hits occur.
				r = $urandom_range(9);
				if (r == 0)
					key = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
				else if (r < 4 && sent_keys.size() != 0)
					key = sent_keys[$urandom_range(sent_keys.size() - 1)];
				else if (r < 6)
					key = $urandom_range(64) - 32;
				else
					key = $urandom;
				push_op(op, key, $urandom, 4'($urandom_range(15)));
			end
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		$display("Sent %0d operations over %0d capacity writes; %0d results compared.",
			ops_sent, cap_writes, checked);
		$display("The table ended holding %0d records after capacities from 0 to 31.",
			records_held);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
